// ===== hdl/tracker_pattern_command_decoder_defines.svh =====
// Assertion helpers shared by the decoder's modules.
`ifndef TRACKER_PATTERN_COMMAND_DECODER_DEFINES_SVH
`define TRACKER_PATTERN_COMMAND_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPCD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TPCD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/tpcd_pkg.sv =====
package tpcd_pkg;

    typedef logic [3:0] event_t;

    localparam event_t EV_NOTE     = 4'd0;
    localparam event_t EV_REST     = 4'd1;
    localparam event_t EV_SAMPLE   = 4'd2;
    localparam event_t EV_ORN      = 4'd3;
    localparam event_t EV_VOL      = 4'd4;
    localparam event_t EV_ORN_OFF  = 4'd5;
    localparam event_t EV_ENV_TYPE = 4'd6;
    localparam event_t EV_ENV_NOTE = 4'd7;
    localparam event_t EV_ENV_TONE = 4'd8;
    localparam event_t EV_PAT_END  = 4'd9;
    localparam event_t EV_EMPTY    = 4'd10;

    localparam logic [6:0] NOTE_START = 7'd48;
    localparam logic [8:0] NOTE_WRAP  = 9'h060;
    localparam logic [7:0] TONE_HI    = 8'hf1;
    localparam logic [11:0] ENV_ORN   = 12'h021;

    // One decoded command waiting for the back end.
    typedef struct packed {
        logic [1:0]  chan;
        logic        triple;    // envelope preset: three results, value holds preset index
        event_t      ev;
        logic [11:0] value;
        logic        row_done;
        logic [6:0]  rows;
    } desc_t;

endpackage

// ===== hdl/tpcd_front.sv =====
module tpcd_front
    import tpcd_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [1:0] s_channel,
    input  logic [7:0] s_cmd_byte,
    input  logic       q_full,
    output logic       q_push,
    output desc_t      q_data
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [6:0] note_reg   [NUM_CHANNELS];
    logic [6:0] period_reg [NUM_CHANNELS];
    logic       await_reg  [NUM_CHANNELS];

    logic            accept;
    logic            in_range;
    logic [CH_W-1:0] idx;
    logic [6:0]      cur_note;
    logic [6:0]      note_next;
    logic [6:0]      per;
    logic            emit;
    logic            set_await;
    logic            set_period;
    logic            upd_note;
    desc_t           d;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_channel) < NUM_CHANNELS);
    assign idx      = CH_W'(s_channel);
    assign cur_note = note_reg[idx];
    assign per      = period_reg[idx];

    always_comb begin
        if ({1'b0, cur_note} >= s_cmd_byte) begin
            note_next = cur_note - s_cmd_byte[6:0];
        end else begin
            note_next = 7'({2'b00, cur_note} + NOTE_WRAP - {1'b0, s_cmd_byte});
        end
    end

    always_comb begin
        d          = '0;
        d.chan     = s_channel;
        emit       = 1'b1;
        set_await  = 1'b0;
        set_period = 1'b0;
        upd_note   = 1'b0;
        if (await_reg[idx]) begin
            d.ev    = EV_ENV_TONE;
            d.value = (s_cmd_byte >= TONE_HI) ? {s_cmd_byte[3:0], 8'h00}
                                              : {4'h0, s_cmd_byte};
        end else if (s_cmd_byte <= 8'h5f) begin
            upd_note   = 1'b1;
            d.ev       = EV_NOTE;
            d.value    = {5'd0, note_next};
            d.row_done = 1'b1;
            d.rows     = per;
        end else if (s_cmd_byte == 8'h60) begin
            d.ev       = EV_REST;
            d.row_done = 1'b1;
            d.rows     = per;
        end else if (s_cmd_byte <= 8'h6f) begin
            d.ev    = EV_SAMPLE;
            d.value = {4'h0, s_cmd_byte - 8'h61};
        end else if (s_cmd_byte <= 8'h8f) begin
            d.ev    = EV_ORN;
            d.value = {4'h0, s_cmd_byte - 8'h70};
        end else if (s_cmd_byte == 8'h90) begin
            d.ev       = EV_EMPTY;
            d.row_done = 1'b1;
            d.rows     = per;
        end else if (s_cmd_byte <= 8'h9f) begin
            d.ev    = EV_VOL;
            d.value = {4'h0, s_cmd_byte - 8'h90};
        end else if (s_cmd_byte == 8'ha0) begin
            d.ev = EV_ORN_OFF;
        end else if (s_cmd_byte <= 8'hb0) begin
            d.ev     = EV_ORN;
            d.triple = 1'b1;
            d.value  = {4'h0, s_cmd_byte - 8'ha1};
        end else if (s_cmd_byte <= 8'hb7) begin
            set_await = 1'b1;
            d.ev      = EV_ENV_TYPE;
            d.value   = {4'h0, s_cmd_byte - 8'ha9};
        end else if (s_cmd_byte <= 8'hf8) begin
            set_period = 1'b1;
            emit       = 1'b0;
        end else if (s_cmd_byte == 8'hf9) begin
            emit = 1'b0;
        end else if (s_cmd_byte <= 8'hfb) begin
            d.ev    = EV_ORN;
            d.value = {4'h0, s_cmd_byte - 8'hda};
        end else begin
            d.ev = EV_PAT_END;
        end
    end

    assign q_push = accept && !s_mode && in_range && emit;
    assign q_data = d;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_mode)) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                note_reg[i]   <= NOTE_START;
                period_reg[i] <= '0;
                await_reg[i]  <= 1'b0;
            end
        end else if (accept && in_range) begin
            if (await_reg[idx]) begin
                await_reg[idx] <= 1'b0;
            end else begin
                if (upd_note) begin
                    note_reg[idx] <= note_next;
                end
                if (set_period) begin
                    period_reg[idx] <= 7'(s_cmd_byte - 8'hb8);
                end
                if (set_await) begin
                    await_reg[idx] <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hdl/tpcd_fifo.sv =====
`include "tracker_pattern_command_decoder_defines.svh"

module tpcd_fifo
    import tpcd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t wr_data,
    input  logic  pop,
    output desc_t rd_data,
    output logic  full,
    output logic  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    desc_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push;
    logic              do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `TPCD_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(DEPTH), "fifo overfill")
    `TPCD_ASSERT_NXT(a_cnt_inc, aclk, aresetn, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "fifo count lost a push")

endmodule

// ===== hdl/tpcd_back.sv =====
`include "tracker_pattern_command_decoder_defines.svh"

module tpcd_back
    import tpcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  desc_t       q_data,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_chan_out,
    output logic [3:0]  m_event_res,
    output logic [11:0] m_value,
    output logic        m_row_done,
    output logic [6:0]  m_rows_to_wait,
    output logic        m_last
);

    logic [1:0]  beat_reg;
    logic        valid_reg;
    logic [1:0]  chan_reg;
    event_t      ev_reg;
    logic [11:0] value_reg;
    logic        done_reg;
    logic [6:0]  rows_reg;
    logic        last_reg;

    logic        head_valid;
    logic        load;
    logic        final_beat;
    event_t      ev_cur;
    logic [11:0] val_cur;
    logic [11:0] env_note_base;

    assign head_valid = !q_empty;
    assign load       = head_valid && (!valid_reg || m_ready);
    assign final_beat = !q_data.triple || (beat_reg == 2'd2);
    assign q_pop      = load && final_beat;

    // preset index p: type 8 + 2*(p&3), note 3*(p&12)
    assign env_note_base = {8'd0, q_data.value[3:2], 2'b00};

    always_comb begin
        ev_cur  = q_data.ev;
        val_cur = q_data.value;
        if (q_data.triple) begin
            unique case (beat_reg)
                2'd0: begin
                    ev_cur  = EV_ORN;
                    val_cur = ENV_ORN;
                end
                2'd1: begin
                    ev_cur  = EV_ENV_TYPE;
                    val_cur = 12'd8 + {9'd0, q_data.value[1:0], 1'b0};
                end
                default: begin
                    ev_cur  = EV_ENV_NOTE;
                    val_cur = env_note_base + {env_note_base[10:0], 1'b0};
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            beat_reg  <= '0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                beat_reg  <= final_beat ? 2'd0 : beat_reg + 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            chan_reg  <= q_data.chan;
            ev_reg    <= ev_cur;
            value_reg <= val_cur;
            done_reg  <= q_data.row_done;
            rows_reg  <= q_data.rows;
            last_reg  <= final_beat;
        end
    end

    assign m_valid        = valid_reg;
    assign m_chan_out     = chan_reg;
    assign m_event_res    = ev_reg;
    assign m_value        = value_reg;
    assign m_row_done     = done_reg;
    assign m_rows_to_wait = rows_reg;
    assign m_last         = last_reg;

    `TPCD_ASSERT_IMP(a_burst_head, aclk, aresetn, beat_reg != 2'd0, head_valid && q_data.triple, "burst lost its queue head")
    `TPCD_ASSERT_IMP(a_rows_zero, aclk, aresetn, valid_reg && !done_reg, rows_reg == 7'd0, "row period on non-row event")

endmodule

// ===== hdl/tracker_pattern_command_decoder.sv =====
// Pattern command decoder for NUM_CHANNELS tracker channels. The front end takes
// one command byte (or a start-of-pattern item) every cycle while the queue is
// not full, updates the channel's note, row period and tone-wait state, and queues
// at most one decoded command per byte into a QUEUE_DEPTH-entry queue. The back
// end drains the queue into a registered result port: one result per cycle while
// m_ready is high, three results for an envelope preset byte. Sustained rate is
// one byte per cycle while the result side keeps up; bursts of envelope presets
// are absorbed by the queue, and s_ready drops only when it is full. Start
// pattern, row-period, no-op and out-of-range channel items produce no result.
module tracker_pattern_command_decoder
    import tpcd_pkg::*;
#(
    parameter int NUM_CHANNELS = 3,
    parameter int QUEUE_DEPTH  = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [1:0]  s_channel,
    input  logic [7:0]  s_cmd_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_chan_out,
    output logic [3:0]  m_event_res,
    output logic [11:0] m_value,
    output logic        m_row_done,
    output logic [6:0]  m_rows_to_wait,
    output logic        m_last
);

    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;
    desc_t q_wr;
    desc_t q_rd;

    tpcd_front #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_mode    (s_mode),
        .s_channel (s_channel),
        .s_cmd_byte(s_cmd_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr)
    );

    tpcd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_fifo (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .wr_data(q_wr),
        .pop    (q_pop),
        .rd_data(q_rd),
        .full   (q_full),
        .empty  (q_empty)
    );

    tpcd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_data        (q_rd),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_chan_out    (m_chan_out),
        .m_event_res   (m_event_res),
        .m_value       (m_value),
        .m_row_done    (m_row_done),
        .m_rows_to_wait(m_rows_to_wait),
        .m_last        (m_last)
    );

endmodule

// ===== sim/tracker_pattern_command_decoder_test.sv =====
`timescale 1ns / 100ps

module tracker_pattern_command_decoder_test;
    import tpcd_pkg::*;

    localparam int NUM_CHANNELS = 3;
    localparam int RANDOM_ITEMS = 85;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 23;

    // command byte map
    localparam logic [7:0] CMD_NOTE_MAX    = 8'h5f;
    localparam logic [7:0] CMD_REST        = 8'h60;
    localparam logic [7:0] CMD_SAMPLE_MIN  = 8'h61;
    localparam logic [7:0] CMD_SAMPLE_MAX  = 8'h6f;
    localparam logic [7:0] CMD_ORN_MIN     = 8'h70;
    localparam logic [7:0] CMD_ORN_MAX     = 8'h8f;
    localparam logic [7:0] CMD_EMPTY       = 8'h90;
    localparam logic [7:0] CMD_VOL_MAX     = 8'h9f;
    localparam logic [7:0] CMD_ORN_OFF     = 8'ha0;
    localparam logic [7:0] CMD_PRESET_MIN  = 8'ha1;
    localparam logic [7:0] CMD_PRESET_MAX  = 8'hb0;
    localparam logic [7:0] CMD_ENV_MIN     = 8'hb1;
    localparam logic [7:0] CMD_ENV_MAX     = 8'hb7;
    localparam logic [7:0] CMD_PERIOD_MIN  = 8'hb8;
    localparam logic [7:0] CMD_PERIOD_MAX  = 8'hf8;
    localparam logic [7:0] CMD_NOP         = 8'hf9;
    localparam logic [7:0] CMD_ORN_ALT_MIN = 8'hfa;
    localparam logic [7:0] CMD_ORN_ALT_MAX = 8'hfb;
    localparam logic [7:0] CMD_PAT_END_MIN = 8'hfc;
    localparam logic [7:0] ENV_TYPE_BIAS   = 8'ha9;
    localparam logic [7:0] ORN_ALT_BIAS    = 8'hda;

    localparam logic MODE_BYTE  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [1:0] chan;
        logic [7:0] cmd;
    } command_item_t;

    typedef struct packed {
        logic [1:0]  chan;
        event_t      ev;
        logic [11:0] value;
        logic        row_done;
        logic [6:0]  rows;
        logic        last;
    } decoded_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_mode = 1'b0;
    logic [1:0]  s_channel = 2'd0;
    logic [7:0]  s_cmd_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_chan_out;
    logic [3:0]  m_event_res;
    logic [11:0] m_value;
    logic        m_row_done;
    logic [6:0]  m_rows_to_wait;
    logic        m_last;

    command_item_t  pending_items[$];
    command_item_t  on_bus;
    decoded_event_t expected_events[$];

    logic [6:0] note_by_chan[NUM_CHANNELS];
    logic [6:0] period_by_chan[NUM_CHANNELS];
    logic       tone_pending[NUM_CHANNELS];

    int items_total = 0;
    int items_accepted = 0;
    int events_checked = 0;
    int row_ends = 0;
    int mismatches = 0;
    int cycle_count = 0;

    // a stretch in the middle of the run with no gaps on either side
    wire steady = items_accepted >= 50 && items_accepted < 85;

    tracker_pattern_command_decoder #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_mode(s_mode),
        .s_channel(s_channel),
        .s_cmd_byte(s_cmd_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_chan_out(m_chan_out),
        .m_event_res(m_event_res),
        .m_value(m_value),
        .m_row_done(m_row_done),
        .m_rows_to_wait(m_rows_to_wait),
        .m_last(m_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic decoded_event_t make_event(input logic [1:0] chan, input event_t ev,
                                                  input logic [11:0] value, input logic done,
                                                  input logic [6:0] rows);
        decoded_event_t e;
        e.chan     = chan;
        e.ev       = ev;
        e.value    = value;
        e.row_done = done;
        e.rows     = done ? rows : 7'd0;
        e.last     = 1'b0;
        return e;
    endfunction

    function automatic void reset_channels();
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            note_by_chan[c]   = NOTE_START;
            period_by_chan[c] = 7'd0;
            tone_pending[c]   = 1'b0;
        end
    endfunction

    // Update channel state for one accepted item and queue the events it causes.
    task automatic decode_command(input command_item_t item);
        decoded_event_t batch[$];
        decoded_event_t e;
        logic [6:0]     rows;
        logic [7:0]     cmd;
        logic [7:0]     preset;
        int             note;
        int             ch;
        cmd = item.cmd;
        ch  = item.chan;
        if (item.mode == MODE_START) begin
            reset_channels();
        end else if (ch < NUM_CHANNELS) begin
            rows = period_by_chan[ch];
            if (tone_pending[ch]) begin
                tone_pending[ch] = 1'b0;
                batch.insert(batch.size(), make_event(item.chan, EV_ENV_TONE,
                    (cmd >= TONE_HI) ? {cmd[3:0], 8'h00} : {4'h0, cmd}, 1'b0, 7'd0));
            end else if (cmd <= CMD_NOTE_MAX) begin
                note = note_by_chan[ch];
                if (note >= cmd)
                    note = note - cmd;
                else
                    note = (note + NOTE_WRAP - cmd) & 'h7f;
                note_by_chan[ch] = note[6:0];
                batch.insert(batch.size(),
                             make_event(item.chan, EV_NOTE, note[11:0], 1'b1, rows));
            end else if (cmd == CMD_REST) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_REST, 12'd0, 1'b1, rows));
            end else if (cmd <= CMD_SAMPLE_MAX) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_SAMPLE, 12'(cmd - CMD_SAMPLE_MIN),
                                        1'b0, 7'd0));
            end else if (cmd <= CMD_ORN_MAX) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ORN, 12'(cmd - CMD_ORN_MIN),
                                        1'b0, 7'd0));
            end else if (cmd == CMD_EMPTY) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_EMPTY, 12'd0, 1'b1, rows));
            end else if (cmd <= CMD_VOL_MAX) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_VOL, 12'(cmd - CMD_EMPTY), 1'b0, 7'd0));
            end else if (cmd == CMD_ORN_OFF) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ORN_OFF, 12'd0, 1'b0, 7'd0));
            end else if (cmd <= CMD_PRESET_MAX) begin
                // envelope preset: fixed ornament, then type and note from the preset index
                preset = cmd - CMD_PRESET_MIN;
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ORN, ENV_ORN, 1'b0, 7'd0));
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ENV_TYPE,
                                        12'(8 + 2 * (preset & 8'd3)), 1'b0, 7'd0));
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ENV_NOTE,
                                        12'(3 * (preset & 8'd12)), 1'b0, 7'd0));
            end else if (cmd <= CMD_ENV_MAX) begin
                tone_pending[ch] = 1'b1;
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ENV_TYPE, 12'(cmd - ENV_TYPE_BIAS),
                                        1'b0, 7'd0));
            end else if (cmd <= CMD_PERIOD_MAX) begin
                period_by_chan[ch] = 7'(cmd - CMD_PERIOD_MIN);
            end else if (cmd == CMD_NOP) begin
            end else if (cmd <= CMD_ORN_ALT_MAX) begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_ORN, 12'(cmd - ORN_ALT_BIAS),
                                        1'b0, 7'd0));
            end else begin
                batch.insert(batch.size(),
                             make_event(item.chan, EV_PAT_END, 12'd0, 1'b0, 7'd0));
            end
        end
        while (batch.size() > 0) begin
            e = batch.pop_front();
            e.last = batch.size() == 0;
            expected_events.insert(expected_events.size(), e);
        end
    endtask

    function automatic void check_field(input string name, input logic [11:0] want,
                                        input logic [11:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic queue_item(input logic mode, input logic [1:0] chan, input logic [7:0] cmd);
        command_item_t item;
        item.mode = mode;
        item.chan = chan;
        item.cmd  = cmd;
        pending_items.insert(pending_items.size(), item);
        items_total++;
    endtask

    task automatic queue_random_item();
        int         pick;
        logic [1:0] chan;
        pick = $urandom_range(99);
        chan = 2'($urandom_range(NUM_CHANNELS - 1));
        if (pick < 3) begin
            queue_item(MODE_START, 2'($urandom_range(3)), 8'($urandom_range(255)));
            return;
        end
        if (pick < 7) begin
            queue_item(MODE_BYTE, 2'd3, 8'($urandom_range(255)));
            return;
        end
        pick = $urandom_range(99);
        if (pick < 35)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_NOTE_MAX)));
        else if (pick < 40)
            queue_item(MODE_BYTE, chan, CMD_REST);
        else if (pick < 45)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_SAMPLE_MIN, CMD_SAMPLE_MAX)));
        else if (pick < 50)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_ORN_MIN, CMD_ORN_MAX)));
        else if (pick < 55)
            queue_item(MODE_BYTE, chan, CMD_EMPTY);
        else if (pick < 61)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_EMPTY + 1, CMD_VOL_MAX)));
        else if (pick < 64)
            queue_item(MODE_BYTE, chan, CMD_ORN_OFF);
        else if (pick < 72)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_PRESET_MIN, CMD_PRESET_MAX)));
        else if (pick < 80) begin
            // envelope type, then its tone byte on the same channel
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_ENV_MIN, CMD_ENV_MAX)));
            if ($urandom_range(1))
                queue_item(MODE_BYTE, chan, 8'($urandom_range(TONE_HI, 8'hff)));
            else
                queue_item(MODE_BYTE, chan, 8'($urandom_range(255)));
        end else if (pick < 90)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_PERIOD_MIN, CMD_PERIOD_MAX)));
        else if (pick < 92)
            queue_item(MODE_BYTE, chan, CMD_NOP);
        else if (pick < 95)
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_ORN_ALT_MIN, CMD_ORN_ALT_MAX)));
        else
            queue_item(MODE_BYTE, chan, 8'($urandom_range(CMD_PAT_END_MIN, 8'hff)));
    endtask

    // input side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_command(on_bus);
                items_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    on_bus = pending_items.pop_front();
                    s_valid    <= 1'b1;
                    s_mode     <= on_bus.mode;
                    s_channel  <= on_bus.chan;
                    s_cmd_byte <= on_bus.cmd;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        decoded_event_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected event transfer: chan %0d event %0d value %0d",
                           m_chan_out, m_event_res, m_value);
                    mismatches++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("chan_out", want.chan, m_chan_out);
                    check_field("event_res", want.ev, m_event_res);
                    check_field("value", want.value, m_value);
                    check_field("row_done", want.row_done, m_row_done);
                    check_field("rows_to_wait", want.rows, m_rows_to_wait);
                    check_field("last", want.last, m_last);
                    events_checked++;
                    if (want.row_done)
                        row_ends++;
                end
            end
            m_ready <= steady || $urandom_range(99) >= IDLE_PCT;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d events still expected",
                     cycle_count, expected_events.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        reset_channels();

        // directed: every command range and most of its edges
        queue_item(MODE_START, 2'd3, 8'hff);
        queue_item(MODE_BYTE, 2'd0, 8'h00);
        queue_item(MODE_BYTE, 2'd0, CMD_NOTE_MAX);             // wraps below zero
        queue_item(MODE_BYTE, 2'd1, CMD_PERIOD_MAX);
        queue_item(MODE_BYTE, 2'd1, 8'h30);
        queue_item(MODE_BYTE, 2'd1, CMD_REST);
        queue_item(MODE_BYTE, 2'd2, CMD_SAMPLE_MIN);
        queue_item(MODE_BYTE, 2'd2, CMD_SAMPLE_MAX);
        queue_item(MODE_BYTE, 2'd2, CMD_ORN_MIN);
        queue_item(MODE_BYTE, 2'd2, CMD_ORN_MAX);
        queue_item(MODE_BYTE, 2'd0, CMD_EMPTY);
        queue_item(MODE_BYTE, 2'd0, CMD_VOL_MAX);
        queue_item(MODE_BYTE, 2'd1, CMD_ORN_OFF);
        queue_item(MODE_BYTE, 2'd1, CMD_PRESET_MIN);
        queue_item(MODE_BYTE, 2'd1, CMD_PRESET_MAX);
        queue_item(MODE_BYTE, 2'd2, CMD_ENV_MIN);
        queue_item(MODE_BYTE, 2'd2, 8'hff);                    // tone in the high form
        queue_item(MODE_BYTE, 2'd0, CMD_ENV_MAX);
        queue_item(MODE_BYTE, 2'd0, 8'hf0);                    // tone just below the high form
        queue_item(MODE_BYTE, 2'd2, CMD_PERIOD_MIN);
        queue_item(MODE_BYTE, 2'd2, CMD_NOP);
        queue_item(MODE_BYTE, 2'd0, CMD_ORN_ALT_MIN);
        queue_item(MODE_BYTE, 2'd0, CMD_ORN_ALT_MAX);
        queue_item(MODE_BYTE, 2'd1, CMD_PAT_END_MIN);
        queue_item(MODE_BYTE, 2'd3, 8'h00);                    // no such channel
        queue_item(MODE_START, 2'd0, 8'h00);
        queue_item(MODE_BYTE, 2'd1, 8'h00);

        repeat (RANDOM_ITEMS)
            queue_random_item();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (items_accepted < items_total)
            @(posedge aclk);
        while (expected_events.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Fed %0d command items over %0d cycles;", items_accepted, cycle_count);
        $display("checked %0d decoded events, %0d of them row ends", events_checked, row_ends);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
